@@ sv/mphm_pkg.sv @@
// ----------------------------------------------------------------------------
// Motor period health monitor package
// Shared widths, register indexes and the control and status bundles that
// pass between the top level and the period tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package mphm_pkg;

	// Width of a timer capture and of a period in ticks.
	localparam int unsigned CAP_W = 16;

	// Width of the running average.
	localparam int unsigned AVG_W = 16;

	// Default number of periods that are averaged.
	localparam int unsigned RING_DEPTH_DEF = 8;

	// Configuration port widths.
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PERIOD_LOW    = 2'd0,
		REG_PERIOD_HIGH   = 2'd1,
		REG_MOTOR_ENABLED = 2'd2
	} cfg_reg_t;

	// Control from the period stage to the tracker.
	typedef struct packed {
		logic load;      // a new period is committed this cycle
		logic backwards; // the capture was below the previous one
		logic enabled;   // the motor is driven on
	} trk_ctl_t;

	// Status from the tracker for the result register.
	typedef struct packed {
		logic fault;
		logic healthy;
	} trk_stat_t;

endpackage

`default_nettype wire

@@ sv/mphm_if.sv @@
// ----------------------------------------------------------------------------
// Motor period health monitor channels
// Valid/ready channels for the capture items and for the result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface mphm_capture_if;
	logic        valid;
	logic        ready;
	logic [15:0] capture_time;

	modport source (output valid, output capture_time, input ready);
	modport sink (input valid, input capture_time, output ready);
endinterface

interface mphm_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] last_period;
	logic [15:0] average_period;
	logic        fault;
	logic        healthy;

	modport source (output valid, output last_period, output average_period,
		output fault, output healthy, input ready);
	modport sink (input valid, input last_period, input average_period,
		input fault, input healthy, output ready);
endinterface

`default_nettype wire

@@ sv/mphm_track.sv @@
// ----------------------------------------------------------------------------
// Motor period tracker
// Keeps the shift line of scaled periods, the running average, the sticky
// fault flag, and judges the health of the motor for each item.
// ----------------------------------------------------------------------------
`default_nettype none

module mphm_track
	import mphm_pkg::*;
#(
	parameter  int unsigned RING_DEPTH = RING_DEPTH_DEF,
	// Width of one period divided by the depth.
	localparam int unsigned QUOT_W     = $clog2(((2 ** CAP_W) - 1) / RING_DEPTH + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire trk_ctl_t              ctl,
	input  wire logic [QUOT_W-1:0]     quot,
	input  wire logic [CAP_W-1:0]      period_low,
	input  wire logic [CAP_W-1:0]      period_high,
	output logic      [AVG_W-1:0]      avg_next,
	output trk_stat_t                  stat
);

	logic [QUOT_W-1:0] ring_q [RING_DEPTH];
	logic [AVG_W-1:0]  avg_q;
	logic              fault_q;
	logic              fault_next;

	// The oldest scaled period leaves the sum, the new one enters it.
	always_comb begin
		avg_next   = avg_q - AVG_W'(ring_q[RING_DEPTH-1]) + AVG_W'(quot);
		fault_next = fault_q | ctl.backwards;
	end

	// Health: always true while disabled, else window check and no fault.
	always_comb begin
		stat.fault   = fault_next;
		stat.healthy = !ctl.enabled
			|| ((avg_next >= period_low) && (avg_next <= period_high) && !fault_next);
	end

	// Shift line of scaled periods; the last tap is the oldest entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RING_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
		end else if (ctl.load) begin
			ring_q[0] <= quot;
			for (int i = 1; i < RING_DEPTH; i++) begin
				ring_q[i] <= ring_q[i-1];
			end
		end
	end

	// Running average and sticky fault.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q   <= '0;
			fault_q <= 1'b0;
		end else if (ctl.load) begin
			avg_q   <= avg_next;
			fault_q <= fault_next;
		end
	end

endmodule

`default_nettype wire

@@ sv/motor_period_health_monitor_top.sv @@
// ----------------------------------------------------------------------------
// Motor period health monitor
// Turns sync pulse captures into periods, a running average and a health
// verdict for the motor.
// ----------------------------------------------------------------------------
// Each capture item yields exactly one result item. The block is a three
// stage pipeline (input register, period and scaling stage, tracker and
// result register) and takes one capture per clock cycle unless the result
// side stalls. A stall on the result side holds the whole pipeline, so
// capture ready follows result ready in the same cycle once the result
// register is full. The average is the sum of the last RING_DEPTH periods
// each divided by RING_DEPTH with truncation, done by a constant reciprocal
// multiply. Configuration should be written through the plain write port
// only while no item is in flight; the block itself does not enforce this.
`default_nettype none

module motor_period_health_monitor_top
	import mphm_pkg::*;
#(
	parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	mphm_capture_if.sink               capture,
	mphm_result_if.source              result
);

	// Reciprocal multiply for an exact truncating divide of a 16-bit period.
	localparam int unsigned DEPTH_LOG = $clog2(RING_DEPTH);
	localparam int unsigned SHIFT     = CAP_W + DEPTH_LOG;
	localparam int unsigned MULT      = ((2 ** SHIFT) + RING_DEPTH - 1) / RING_DEPTH;
	localparam int unsigned MULT_W    = CAP_W + 1;
	localparam int unsigned PROD_W    = CAP_W + MULT_W;
	localparam int unsigned QUOT_W    = $clog2(((2 ** CAP_W) - 1) / RING_DEPTH + 1);

	// Configuration registers.
	logic [CAP_W-1:0] period_low_q;
	logic [CAP_W-1:0] period_high_q;
	logic             motor_enabled_q;

	// Pipeline registers.
	logic              valid_s1;
	logic [CAP_W-1:0]  cap_s1;
	logic              valid_s2;
	logic [CAP_W-1:0]  period_s2;
	logic [QUOT_W-1:0] quot_s2;
	logic              back_s2;
	logic              valid_s3;
	logic [CAP_W-1:0]  period_s3;
	logic [AVG_W-1:0]  avg_s3;
	logic              fault_s3;
	logic              healthy_s3;

	logic [CAP_W-1:0]  prev_cap_q;

	logic              en;
	logic [CAP_W-1:0]  period;
	logic [PROD_W-1:0] prod;
	logic [QUOT_W-1:0] quot;
	logic [AVG_W-1:0]  avg_next;
	trk_ctl_t          trk_ctl;
	trk_stat_t         trk_stat;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_low_q    <= '0;
			period_high_q   <= '1;
			motor_enabled_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PERIOD_LOW:    period_low_q    <= cfg_data[CAP_W-1:0];
				REG_PERIOD_HIGH:   period_high_q   <= cfg_data[CAP_W-1:0];
				REG_MOTOR_ENABLED: motor_enabled_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The whole pipeline moves unless a finished result is still waiting.
	assign en            = !valid_s3 || result.ready;
	assign capture.ready = en;

	// Stage one: input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= capture.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && capture.valid) begin
			cap_s1 <= capture.capture_time;
		end
	end

	// Period modulo 2^16 and its share of the average.
	always_comb begin
		period = cap_s1 - prev_cap_q;
		prod   = PROD_W'(period) * PROD_W'(MULT);
		quot   = prod[SHIFT +: QUOT_W];
	end

	// The previous capture follows each item leaving stage one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_cap_q <= '0;
		end else if (en && valid_s1) begin
			prev_cap_q <= cap_s1;
		end
	end

	// Stage two: period, scaled period and backwards flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			period_s2 <= period;
			quot_s2   <= quot;
			back_s2   <= cap_s1 < prev_cap_q;
		end
	end

	// Ring, running average, fault and health.
	always_comb begin
		trk_ctl.load      = en && valid_s2;
		trk_ctl.backwards = back_s2;
		trk_ctl.enabled   = motor_enabled_q;
	end

	mphm_track #(
		.RING_DEPTH (RING_DEPTH)
	) u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (trk_ctl),
		.quot        (quot_s2),
		.period_low  (period_low_q),
		.period_high (period_high_q),
		.avg_next    (avg_next),
		.stat        (trk_stat)
	);

	// Stage three: result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s2) begin
			period_s3  <= period_s2;
			avg_s3     <= avg_next;
			fault_s3   <= trk_stat.fault;
			healthy_s3 <= trk_stat.healthy;
		end
	end

	assign result.valid          = valid_s3;
	assign result.last_period    = period_s3;
	assign result.average_period = avg_s3;
	assign result.fault          = fault_s3;
	assign result.healthy        = healthy_s3;

`ifndef NO_ASSERTIONS
	// A committed item always reaches the result register next cycle.
	a_commit_reaches_result: assert property (@(posedge clk) disable iff (!arst_n)
		(en && valid_s2) |=> valid_s3)
		else $error("committed item did not reach the result register");

	// The fault flag never clears once set.
	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		u_track.fault_q |=> u_track.fault_q)
		else $error("sticky fault flag cleared");

	// A result carrying a fault agrees with the latched flag.
	a_fault_latched: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && fault_s3) |-> u_track.fault_q)
		else $error("result fault without latched flag");
`endif

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Motor period health monitor testbench
// Sends capture items through the block and checks every result item against
// a cycle-free predictor of the period, the running average, the sticky fault
// and the health verdict. Both channels idle and stall at random. The
// configuration changes only while no item is in flight.
// ----------------------------------------------------------------------------

module testbench;
	import mphm_pkg::*;

	localparam int unsigned RING_DEPTH = RING_DEPTH_DEF;
	localparam int HEALTHY_ITEMS = 600;
	localparam int TOTAL_ITEMS = 1150;
	localparam int SETTLE_CYCLES = 8;
	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD = 400;

	// One expected result item.
	typedef struct packed {
		logic [CAP_W-1:0] last_period;
		logic [AVG_W-1:0] average_period;
		logic             fault;
		logic             healthy;
	} period_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mphm_capture_if capture_ch();
	mphm_result_if  result_ch();

	motor_period_health_monitor_top #(
		.RING_DEPTH(RING_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.capture(capture_ch),
		.result(result_ch)
	);

	// Tracker state and register copies kept by the testbench.
	logic [CAP_W-1:0] last_capture_q;
	logic [CAP_W-1:0] period_hist [RING_DEPTH];
	int unsigned      hist_slot;
	logic [AVG_W-1:0] avg_sum;
	logic             fault_seen;
	logic [15:0]      win_low;
	logic [15:0]      win_high;
	logic             motor_on;

	period_result_t pending_results [$];
	int mismatch_count;
	int items_sent;
	int burst_left;
	bit steady_sender;
	int hold_request;
	int hold_left;
	int rx_cycle;
	int idle_cycles;

	always #1 clk = ~clk;

	// Advance the tracker by one capture and return the result it should give.
	function automatic period_result_t track_capture(input logic [CAP_W-1:0] cap);
		period_result_t   r;
		logic [CAP_W-1:0] period;
		logic [CAP_W-1:0] oldest;
		if (cap < last_capture_q) begin
			fault_seen = 1'b1;
		end
		period = cap - last_capture_q;
		last_capture_q = cap;
		oldest = period_hist[hist_slot];
		avg_sum = avg_sum - AVG_W'(oldest / RING_DEPTH) + AVG_W'(period / RING_DEPTH);
		period_hist[hist_slot] = period;
		hist_slot = (hist_slot + 1) % RING_DEPTH;
		r.last_period = period;
		r.average_period = avg_sum;
		r.fault = fault_seen;
		r.healthy = !motor_on || (avg_sum >= win_low && avg_sum <= win_high && !fault_seen);
		return r;
	endfunction

	function automatic logic [15:0] clamp16(input int v);
		if (v < 0) begin
			return 16'd0;
		end
		if (v > 65535) begin
			return 16'hFFFF;
		end
		return 16'(v);
	endfunction

	// Window bounds that favor the extremes of the field.
	function automatic logic [15:0] pick_bound();
		case ($urandom_range(0, 3))
			0: begin
				return 16'd0;
			end
			1: begin
				return 16'hFFFF;
			end
			default: begin
				return 16'($urandom_range(0, 65535));
			end
		endcase
	endfunction

	task automatic compare_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Offer one capture item, with a burst gap in front when one is due.
	task automatic send_capture(input logic [CAP_W-1:0] cap);
		int gap;
		gap = 0;
		if (!steady_sender) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
				burst_left = $urandom_range(1, 24);
			end
			burst_left--;
		end
		if (gap > 0) begin
			@(negedge clk);
			capture_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		capture_ch.valid <= 1'b1;
		capture_ch.capture_time <= cap;
		do @(posedge clk); while (!capture_ch.ready);
		pending_results.push_back(track_capture(cap));
		items_sent++;
	endtask

	// Stop offering and wait until every expected result item has come back.
	task automatic drain_results();
		@(negedge clk);
		capture_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_PERIOD_LOW: begin
				win_low = value;
			end
			REG_PERIOD_HIGH: begin
				win_high = value;
			end
			REG_MOTOR_ENABLED: begin
				motor_on = value[0];
			end
			default: begin
			end
		endcase
	endtask

	task automatic configure(input logic [15:0] lo, input logic [15:0] hi, input logic en);
		drain_results();
		write_reg(REG_PERIOD_LOW, lo);
		write_reg(REG_PERIOD_HIGH, hi);
		write_reg(REG_MOTOR_ENABLED, CFG_DATA_W'(en));
	endtask

	// First capture after reset, an equal capture, then a few rising ones.
	task automatic test_first_capture();
		send_capture(16'd1000);
		send_capture(16'd1000);
		configure(16'd0, 16'hFFFF, 1'b1);
		send_capture(16'd1008);
		send_capture(16'd1100);
		send_capture(16'd1300);
	endtask

	// Fill the ring with a fixed period, then move the window across the average.
	task automatic test_health_window();
		int   lows [7] = '{80, 81, 0, 90, 0, 65535, 90};
		int   highs [7] = '{80, 65535, 79, 10, 0, 65535, 10};
		logic ens [7] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
		repeat (RING_DEPTH) send_capture(last_capture_q + 16'd80);
		for (int i = 0; i < 7; i++) begin
			configure(16'(lows[i]), 16'(highs[i]), ens[i]);
			send_capture(last_capture_q + 16'd80);
		end
	endtask

	// Rising captures around a base period, with windows placed near the average.
	task automatic test_random_healthy();
		int          base;
		int          jitter;
		int          margin;
		int          period;
		int          goal;
		logic [15:0] lo;
		logic [15:0] hi;
		logic        en;
		bit          first;
		goal = items_sent + HEALTHY_ITEMS;
		first = 1'b1;
		while (items_sent < goal) begin
			base = int'($urandom_range(0, 140));
			jitter = int'($urandom_range(0, 16));
			margin = int'($urandom_range(0, jitter + 4));
			case ($urandom_range(0, 5))
				0: begin
					lo = clamp16(base - margin - 4);
					hi = clamp16(base + margin);
				end
				1: begin
					lo = clamp16(base + 1 + margin);
					hi = 16'hFFFF;
				end
				2: begin
					lo = 16'd0;
					hi = clamp16(base - 6 - margin);
				end
				3: begin
					lo = clamp16(base - 4);
					hi = lo;
				end
				4: begin
					lo = 16'hFFFF;
					hi = 16'd0;
				end
				default: begin
					lo = 16'd0;
					hi = 16'hFFFF;
				end
			endcase
			en = ($urandom_range(0, 5) != 0);
			configure(lo, hi, en);
			steady_sender = ($urandom_range(0, 3) == 0);
			// The first run meets a long receiver stall so the pipeline backs up.
			if (first) begin
				hold_request = LONG_HOLD;
				steady_sender = 1'b1;
				first = 1'b0;
			end
			repeat ($urandom_range(20, 80)) begin
				period = base - jitter + int'($urandom_range(0, 2 * jitter));
				if (period < 0) begin
					period = 0;
				end
				if (int'(last_capture_q) + period > 65535) begin
					period = 0;
				end
				send_capture(last_capture_q + CAP_W'(period));
			end
		end
		steady_sender = 1'b0;
	endtask

	// Largest capture, an equal one, then a wrap back to zero that latches the fault.
	task automatic test_backwards_capture();
		configure(16'd0, 16'hFFFF, 1'b1);
		send_capture(16'hFFFF);
		send_capture(16'hFFFF);
		send_capture(16'd0);
		// A disabled motor is healthy even with the fault latched and an empty window.
		configure(16'd90, 16'd10, 1'b0);
		send_capture(16'd5);
	endtask

	// Free captures, rising and falling runs and random periods after the fault.
	task automatic test_random_after_fault();
		int               shape;
		int               count;
		logic [CAP_W-1:0] cap;
		while (items_sent < TOTAL_ITEMS) begin
			configure(pick_bound(), pick_bound(), 1'($urandom_range(0, 1)));
			steady_sender = ($urandom_range(0, 3) == 0);
			shape = int'($urandom_range(0, 3));
			count = (shape == 2) ? int'($urandom_range(9, 20)) : int'($urandom_range(10, 60));
			repeat (count) begin
				case (shape)
					0: begin
						cap = 16'($urandom);
					end
					1: begin
						cap = last_capture_q + 16'($urandom_range(0, 300));
					end
					2: begin
						// Falling by one gives the largest period and the largest average.
						cap = last_capture_q - 16'd1;
					end
					default: begin
						cap = last_capture_q + 16'($urandom);
					end
				endcase
				send_capture(cap);
			end
		end
		steady_sender = 1'b0;
	endtask

	// Receiver stall pattern, with a long hold-off on request.
	always @(negedge clk) begin
		rx_cycle++;
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			case ((rx_cycle / 97) % 4)
				0: begin
					result_ch.ready <= 1'b1;
				end
				1: begin
					result_ch.ready <= 1'($urandom_range(0, 1));
				end
				2: begin
					result_ch.ready <= ($urandom_range(0, 4) != 0);
				end
				default: begin
					result_ch.ready <= ((rx_cycle % 7) >= 3);
				end
			endcase
		end
	end

	// Compare each result item with the oldest expectation.
	always @(posedge clk) begin
		period_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result item with no expectation, expected none, actual %0d %0d %0d %0d",
					$time, result_ch.last_period, result_ch.average_period,
					result_ch.fault, result_ch.healthy);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("last_period", want.last_period, result_ch.last_period);
				compare_field("average_period", want.average_period, result_ch.average_period);
				compare_field("fault", want.fault, result_ch.fault);
				compare_field("healthy", want.healthy, result_ch.healthy);
			end
		end
	end

	// Watchdog on cycles in which no item moves on either channel.
	always @(posedge clk) begin
		if (!arst_n || (capture_ch.valid && capture_ch.ready)
			|| (result_ch.valid && result_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("** motor_period_health_monitor_top: FAILED **");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_PERIOD_LOW;
		cfg_data = '0;
		capture_ch.valid = 1'b0;
		capture_ch.capture_time = '0;
		result_ch.ready = 1'b0;
		last_capture_q = '0;
		foreach (period_hist[i]) begin
			period_hist[i] = '0;
		end
		hist_slot = 0;
		avg_sum = '0;
		fault_seen = 1'b0;
		win_low = 16'd0;
		win_high = 16'hFFFF;
		motor_on = 1'b0;
		mismatch_count = 0;
		items_sent = 0;
		burst_left = 0;
		steady_sender = 1'b0;
		hold_request = 0;
		hold_left = 0;
		rx_cycle = 0;
		idle_cycles = 0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_first_capture();
		test_health_window();
		test_random_healthy();
		test_backwards_capture();
		test_random_after_fault();
		drain_results();

		if (mismatch_count == 0) begin
			$display("** motor_period_health_monitor_top: PASSED **");
		end else begin
			$display("** motor_period_health_monitor_top: FAILED **");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/mphm_pkg.sv
sv/mphm_if.sv
sv/mphm_track.sv
sv/motor_period_health_monitor_top.sv
tb/testbench.sv
